// ===== hw/rtl/lts_pkg.sv =====
package lts_pkg;

  localparam int NumSensors = 5;
  localparam int SensW      = 12;
  localparam int PosW       = 14;
  localparam int CfgIdxW    = 8;
  localparam int CfgDataW   = 12;
  localparam int InDataW    = ((NumSensors * SensW + PosW + 1 + 7) / 8) * 8;
  localparam int OutDataW   = 8;

  localparam logic [CfgIdxW-1:0] REG_FULL_SCALE   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_ON_TRACK_THR = 8'd1;

  localparam logic [SensW-1:0] DefFullScale = 12'd1000;
  localparam logic [SensW-1:0] DefOnTrack   = 12'd200;

  // line pattern thresholds are full scale * 3/10 and * 7/10
  localparam int LineLowPct  = 3;
  localparam int LineHighPct = 7;
  localparam int PctDiv      = 10;
  localparam int DivShift    = 19;
  localparam int DivRecip    = ((1 << DivShift) + PctDiv - 1) / PctDiv;
  localparam logic [31:0] MulLow  = 32'(DivRecip * LineLowPct);
  localparam logic [31:0] MulHigh = 32'(DivRecip * LineHighPct);

  localparam logic [2:0] ST_NORMAL    = 3'd0;
  localparam logic [2:0] ST_LINE      = 3'd1;
  localparam logic [2:0] ST_GAP       = 3'd2;
  localparam logic [2:0] ST_MANOEUVRE = 3'd3;
  localparam logic [2:0] ST_FINISHED  = 3'd4;

  localparam logic [1:0] LAP_EV_NONE  = 2'd0;
  localparam logic [1:0] LAP_EV_START = 2'd1;
  localparam logic [1:0] LAP_EV_STOP  = 2'd2;

  typedef enum logic [4:0] {
    TS_NORMAL    = 5'b00001,
    TS_LINE      = 5'b00010,
    TS_GAP       = 5'b00100,
    TS_MANOEUVRE = 5'b01000,
    TS_FINISHED  = 5'b10000
  } track_state_t;

  typedef enum logic [2:0] {
    LAP_NONE  = 3'b001,
    LAP_START = 3'b010,
    LAP_STOP  = 3'b100
  } lap_state_t;

  typedef struct packed {
    logic [SensW-1:0] full_scale;
    logic [SensW-1:0] thr;
    logic [SensW-1:0] t30;
    logic [SensW-1:0] t70;
    logic [PosW-1:0]  mid_lo;
    logic [PosW-1:0]  mid_hi;
    logic [PosW-1:0]  gap_lo;
    logic [PosW-1:0]  gap_hi;
  } lts_cfg_t;

  typedef struct packed {
    logic            mode;
    logic            line_pat;
    logic            lost;
    logic            mid_ok;
    logic            timed_out;
    logic [PosW-1:0] pos;
  } lts_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] lap_event;
    logic       aborted;
    logic       track_lost;
    logic       drive_enable;
  } lts_result_t;

  function automatic lts_cfg_t cfg_calc(input logic [SensW-1:0] fs,
                                        input logic [SensW-1:0] thr);
    lts_cfg_t        c;
    logic [31:0]     p30;
    logic [31:0]     p70;
    logic [PosW-1:0] fs2;
    logic [PosW-1:0] half;
    p30  = 32'(fs) * MulLow;
    p70  = 32'(fs) * MulHigh;
    fs2  = {1'b0, fs, 1'b0};
    half = PosW'(fs >> 1);
    c.full_scale = fs;
    c.thr        = thr;
    c.t30        = SensW'(p30 >> DivShift);
    c.t70        = SensW'(p70 >> DivShift);
    c.mid_lo     = fs2 - half;
    c.mid_hi     = fs2 + half;
    c.gap_lo     = PosW'(fs);
    c.gap_hi     = fs2 + PosW'(fs);
    return c;
  endfunction

  function automatic logic [2:0] status_code(input track_state_t s);
    logic [2:0] code;
    unique case (s)
      TS_NORMAL:    code = ST_NORMAL;
      TS_LINE:      code = ST_LINE;
      TS_GAP:       code = ST_GAP;
      TS_MANOEUVRE: code = ST_MANOEUVRE;
      TS_FINISHED:  code = ST_FINISHED;
      default:      code = ST_NORMAL;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/lts_front.sv =====
module lts_front import lts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output lts_item_t           q_item,
  output lts_cfg_t            cfg
);

  lts_cfg_t         cfg_r;
  lts_cfg_t         cfg_nxt;
  logic [SensW-1:0] sens [NumSensors];
  logic [PosW-1:0]  pos;
  logic             seen;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      if (cfg_index == REG_FULL_SCALE) begin
        cfg_nxt = cfg_calc(cfg_data, cfg_r.thr);
      end else if (cfg_index == REG_ON_TRACK_THR) begin
        cfg_nxt.thr = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_calc(DefFullScale, DefOnTrack);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classification of one transaction
  always_comb begin
    for (int i = 0; i < NumSensors; i++) begin
      sens[i] = in_tdata[i*SensW +: SensW];
    end
    pos  = in_tdata[NumSensors*SensW +: PosW];
    seen = 1'b0;
    for (int i = 0; i < NumSensors; i++) begin
      seen = seen | (sens[i] >= cfg_r.thr);
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.mode      = in_tuser;
    q_item.lost      = !seen;
    q_item.line_pat  = (sens[0] >= cfg_r.t30) && (sens[1] < cfg_r.t70) &&
                       (sens[2] >= cfg_r.t70) && (sens[3] < cfg_r.t70) &&
                       (sens[NumSensors-1] >= cfg_r.t30);
    q_item.mid_ok    = (pos >= cfg_r.mid_lo) && (pos <= cfg_r.mid_hi) &&
                       (sens[0] < cfg_r.thr) && (sens[NumSensors-1] < cfg_r.thr);
    q_item.timed_out = in_tdata[NumSensors*SensW + PosW];
    q_item.pos       = pos;
  end

endmodule

// ===== hw/rtl/lts_queue.sv =====
module lts_queue import lts_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lts_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output lts_item_t pop_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  lts_item_t       mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;

  assign full      = (cnt_r == CntW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(DEPTH)) else $error("queue count past depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
`endif

endmodule

// ===== hw/rtl/lts_back.sv =====
module lts_back import lts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lts_item_t           q_item,
  output logic                q_pop,
  input  lts_cfg_t            cfg,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata
);

  track_state_t    state_r;
  track_state_t    state_nxt;
  lap_state_t      lap_r;
  lap_state_t      lap_nxt;
  logic [PosW-1:0] prev_r;
  logic [PosW-1:0] prev_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  lts_result_t     res_r;
  lts_result_t     res_nxt;
  track_state_t    nxt;
  logic [1:0]      lap_ev;
  logic            prev_in_gap;

  assign q_pop       = q_valid && (!out_valid_r || out_tready);
  assign prev_in_gap = (prev_r >= cfg.gap_lo) && (prev_r < cfg.gap_hi);

  always_comb begin
    state_nxt     = state_r;
    lap_nxt       = lap_r;
    prev_nxt      = prev_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    nxt           = TS_NORMAL;
    lap_ev        = LAP_EV_NONE;

    if (state_r == TS_LINE) begin
      nxt = q_item.mid_ok ? TS_NORMAL : TS_LINE;
    end else if (q_item.line_pat) begin
      nxt = TS_LINE;
    end else if (q_item.lost) begin
      nxt = prev_in_gap ? TS_GAP : TS_MANOEUVRE;
    end
    if (state_r != TS_LINE && nxt == TS_LINE) begin
      if (lap_r == LAP_NONE) begin
        lap_ev = LAP_EV_START;
      end else begin
        lap_ev = LAP_EV_STOP;
        nxt    = TS_FINISHED;
      end
    end
    if (q_item.timed_out) begin
      nxt = TS_FINISHED;
    end

    if (q_pop) begin
      out_valid_nxt = 1'b1;
      if (!q_item.mode) begin
        state_nxt = TS_NORMAL;
        lap_nxt   = LAP_NONE;
        res_nxt   = '{status: ST_NORMAL, lap_event: LAP_EV_NONE, aborted: 1'b0,
                      track_lost: 1'b0, drive_enable: 1'b1};
      end else if (state_r == TS_FINISHED) begin
        res_nxt   = '{status: ST_FINISHED, lap_event: LAP_EV_NONE, aborted: 1'b0,
                      track_lost: 1'b0, drive_enable: 1'b0};
      end else begin
        state_nxt = nxt;
        prev_nxt  = q_item.pos;
        if (lap_ev == LAP_EV_START) begin
          lap_nxt = LAP_START;
        end else if (lap_ev == LAP_EV_STOP) begin
          lap_nxt = LAP_STOP;
        end
        res_nxt   = '{status: status_code(nxt), lap_event: lap_ev,
                      aborted: q_item.timed_out, track_lost: q_item.lost,
                      drive_enable: (nxt != TS_FINISHED)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TS_NORMAL;
      lap_r       <= LAP_NONE;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lap_r       <= lap_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.drive_enable, res_r.track_lost, res_r.aborted,
                       res_r.lap_event, res_r.status};

`ifndef SYNTH
  a_drive_vs_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.drive_enable == (res_r.status != ST_FINISHED)))
    else $error("drive enable disagrees with status");
  a_stop_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.lap_event == LAP_EV_STOP) |-> res_r.status == ST_FINISHED)
    else $error("lap stop without finish");
  a_abort_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.aborted) |-> res_r.status == ST_FINISHED)
    else $error("abort without finish");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_item.mode) |=> (state_r == TS_NORMAL && lap_r == LAP_NONE))
    else $error("restart did not clear state");
`endif

endmodule

// ===== hw/rtl/line_track_status_tracker.sv =====
// an accepted transaction is written to the queue, then popped into the output register
// throughput: one per cycle unless stalled; a two-entry queue between classifier and tracker
// the output register frees itself in the cycle out_tready takes the result
// reset (rst_n low, synchronous): status normal, no start line seen, position 0
// reset also loads full scale 1000 and on-track threshold 200
module line_track_status_tracker import lts_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // left, left_mid, middle, right_mid, right (12 each), line_position (14), timed_out, pad
  input  logic [InDataW-1:0]  in_tdata,
  // mode
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // track_status (3), lap_event (2), aborted, track_lost, drive_enable
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  lts_item_t push_item;
  lts_item_t pop_item;
  lts_cfg_t  cfg;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;

  lts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item),
    .cfg       (cfg)
  );

  lts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  lts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
